// ===== src/fdsf_pkg.sv =====
// Shared constants, types and functions for the segment display feeder.
package fdsf_pkg;

	// Number of decimal digits shown
	localparam int unsigned DIGIT_COUNT = 4;

	// Power of ten, worked out at elaboration
	function automatic longint unsigned pow10(input int unsigned n);
		longint unsigned r;
		r = 64'd1;
		for (int unsigned i = 0; i < n; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

	localparam longint unsigned LIMIT      = pow10(DIGIT_COUNT) - 64'd1;
	localparam int unsigned     NUM_W      = $clog2(LIMIT + 64'd1);
	localparam int unsigned     ITEM_COUNT = DIGIT_COUNT + 3;
	localparam int unsigned     CNT_W      = $clog2(ITEM_COUNT);
	localparam int unsigned     BR_W       = 3;

	// Command bytes of the two-wire controller
	localparam logic [7:0] CMD_DATA = 8'h40;
	localparam logic [7:0] CMD_ADDR = 8'hC0;
	localparam logic [7:0] CMD_CTRL = 8'h88;

	// Byte slots within one frame group
	localparam logic [CNT_W-1:0] SLOT_DATA  = CNT_W'(0);
	localparam logic [CNT_W-1:0] SLOT_ADDR  = CNT_W'(1);
	localparam logic [CNT_W-1:0] SLOT_LSEG  = CNT_W'(DIGIT_COUNT + 1);
	localparam logic [CNT_W-1:0] SLOT_CTRL  = CNT_W'(DIGIT_COUNT + 2);

	typedef logic [DIGIT_COUNT-1:0][7:0] seg_bytes_t;

	// Seven-segment pattern, bit 0 = segment a, decimal point off
	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] s;
		case (digit)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== src/four_digit_segment_display_feeder.sv =====
// Top level: clamps a number, converts it to segment bytes and emits the framed byte stream.
// Order: a start transfer is registered in stage 1 and moves to stage 2 once it is free;
// the first byte is then on the ports and the rest follow one per cycle, DIGIT_COUNT + 3
// bytes (seven). The next number is taken and converted while the previous one is still
// being emitted.
// Reset: arst_n clears all control state and sets brightness to 7; the receiver cannot stall.
module four_digit_segment_display_feeder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [31:0]         value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fdsf_pkg::BR_W-1:0]  cfg_data,
	output logic                       strobe,
	output logic [7:0]                 byte_value,
	output logic                       start_before,
	output logic                       stop_after,
	output logic                       last
);
	import fdsf_pkg::*;

	logic [BR_W-1:0]  brightness_q;
	logic             valid_s1;
	logic [NUM_W-1:0] num_s1;
	logic             valid_s2;
	seg_bytes_t       seg_s2;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             s2_free;
	logic             advance;
	logic [NUM_W-1:0] num_clamped;
	seg_bytes_t       seg_next;

	// Brightness register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BR_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			brightness_q <= cfg_data;
		end
	end

	// Flow control between the input stage and the emitter
	assign s2_free = !valid_s2 || (cnt_q == SLOT_CTRL);
	assign advance = valid_s1 && s2_free;
	assign busy    = valid_s1 && !s2_free;
	assign accept  = start && !busy;

	// Saturate to 0 .. LIMIT
	always_comb begin
		if (value[31]) begin
			num_clamped = '0;
		end else if (32'(value) > 32'(LIMIT)) begin
			num_clamped = NUM_W'(LIMIT);
		end else begin
			num_clamped = NUM_W'(value);
		end
	end

	// Stage 1: clamped number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_s1 <= num_clamped;
		end
	end

	fdsf_digits u_digits (
		.num (num_s1),
		.seg (seg_next)
	);

	// Stage 2: segment bytes and the byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_q    <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			cnt_q    <= '0;
		end else if (valid_s2) begin
			if (cnt_q == SLOT_CTRL) begin
				valid_s2 <= 1'b0;
				cnt_q    <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Segment bytes shift out most significant digit first
	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s2 <= seg_next;
		end else if (valid_s2 && cnt_q > SLOT_ADDR && cnt_q <= SLOT_LSEG) begin
			seg_s2 <= seg_s2 >> 8;
		end
	end

	// Byte selection by slot
	assign strobe = valid_s2;

	always_comb begin
		byte_value   = seg_s2[0];
		start_before = 1'b0;
		stop_after   = (cnt_q == SLOT_LSEG);
		last         = 1'b0;
		if (cnt_q == SLOT_DATA) begin
			byte_value   = CMD_DATA;
			start_before = 1'b1;
			stop_after   = 1'b1;
		end else if (cnt_q == SLOT_ADDR) begin
			byte_value   = CMD_ADDR;
			start_before = 1'b1;
			stop_after   = 1'b0;
		end else if (cnt_q == SLOT_CTRL) begin
			byte_value   = CMD_CTRL | 8'(brightness_q);
			start_before = 1'b1;
			stop_after   = 1'b1;
			last         = 1'b1;
		end
	end

endmodule

// ===== src/fdsf_digits.sv =====
// Splits a clamped number into decimal digits and maps them to segment patterns.
module fdsf_digits (
	input  logic [fdsf_pkg::NUM_W-1:0] num,
	output fdsf_pkg::seg_bytes_t       seg
);
	import fdsf_pkg::*;

	// quo[i] = num / 10^i
	logic [NUM_W-1:0] quo [0:DIGIT_COUNT];

	assign quo[0]           = num;
	assign quo[DIGIT_COUNT] = '0;

	// Division by each power of ten as a reciprocal multiply, all in parallel
	for (genvar gi = 1; gi < DIGIT_COUNT; gi++) begin : g_div
		localparam longint unsigned DIV = pow10(gi);
		localparam int unsigned     SH  = NUM_W + $clog2(DIV) + 1;
		localparam longint unsigned MUL = ((64'd1 << SH) + DIV - 64'd1) / DIV;
		localparam int unsigned     MW  = SH - $clog2(DIV) + 2;
		localparam int unsigned     PW  = NUM_W + MW;

		logic [PW-1:0] prod;

		assign prod    = PW'(num) * PW'(MUL);
		assign quo[gi] = NUM_W'(prod >> SH);
	end

	// Digit = quotient minus ten times the next quotient; most significant first
	for (genvar gi = 0; gi < DIGIT_COUNT; gi++) begin : g_dig
		logic [NUM_W-1:0] tens;
		logic [3:0]       digit;

		assign tens  = NUM_W'({quo[gi+1], 3'b000}) + NUM_W'({quo[gi+1], 1'b0});
		assign digit = 4'(quo[gi] - tens);
		assign seg[DIGIT_COUNT-1-gi] = seg_of(digit);
	end

endmodule
